FILE: sv/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg: shared constants and types for the smoothed heaviside phase unit
// fixed-point formats, horner divisor tables, pipeline sideband struct
// ----------------------------------------------------------------------------
package shp_pkg;

    // fraction bits of distance, half width, reciprocal and phase output
    localparam int FRACTION_BITS = 16;
    localparam int PHASE_W       = FRACTION_BITS + 1;
    localparam int OUT_TDATA_W   = ((PHASE_W + 7) / 8) * 8;
    localparam int Q30_SHIFT     = 30 - FRACTION_BITS;

    localparam logic [PHASE_W-1:0] ONE_F  = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [63:0]        HALF_F = 64'd1 << (FRACTION_BITS - 1);

    // internal band maths in unsigned q2.30
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [30:0] HALF_Q30   = 31'h2000_0000;
    localparam logic [30:0] ROUND_Q30  = 31'((64'd1 << Q30_SHIFT) >> 1);
    localparam logic [31:0] PI_Q30     = 32'd3373259426;
    localparam logic [27:0] INV2PI_Q30 = 28'd170891319;

    // horner chain for the sine series, innermost term first
    localparam int HORNER_CELLS = 5;
    localparam int DIV_W        = 7;
    localparam logic [DIV_W-1:0] HORNER_DIV [HORNER_CELLS] =
        '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
    // floor(2^32 / divisor), estimate is low by at most one
    localparam logic [31:0] HORNER_RECIP [HORNER_CELLS] = '{
        32'(33'h1_0000_0000 / 33'd110),
        32'(33'h1_0000_0000 / 33'd72),
        32'(33'h1_0000_0000 / 33'd42),
        32'(33'h1_0000_0000 / 33'd20),
        32'(33'h1_0000_0000 / 33'd6)
    };

    // configuration register indexes
    typedef enum logic {
        REG_HALF_WIDTH         = 1'b0,
        REG_INVERSE_HALF_WIDTH = 1'b1
    } reg_index_t;

    // per-item control that travels alongside the datapath
    typedef struct packed {
        logic               valid;
        logic               neg;      // distance was negative
        logic               outside;  // |psi| > eps, result is a constant
        logic [PHASE_W-1:0] m;        // |t| in q.f, saturated to one
        logic [30:0]        z;        // sine argument, q30
    } side_t;

endpackage

FILE: sv/shp_front.sv
// ----------------------------------------------------------------------------
// shp_front: band test, scaling by the reciprocal, folding and squaring
// five register stages ahead of the horner chain
// ----------------------------------------------------------------------------
module shp_front import shp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        ce,
    input  logic        in_valid,
    input  logic [31:0] in_distance,
    input  logic [30:0] half_width,
    input  logic [31:0] inverse_half_width,
    output side_t       side_out,
    output logic [31:0] z2_out
);

    logic [31:0]              psi_reg;
    logic                     v1_reg;
    side_t                    s2_reg, s2_next;
    logic [63:0]              prod_reg, prod_next;
    side_t                    s3_reg, s3_next;
    logic [FRACTION_BITS-1:0] y_reg, y_next;
    side_t                    s4_reg;
    logic [FRACTION_BITS+31:0] pp_reg, pp_next;
    side_t                    s5_reg, s5_next;
    logic [61:0]              z2p_reg, z2p_next;

    logic [31:0] mag;
    logic [63:0] rnd;
    logic [63:0] mq;
    logic [30:0] z;

    // stage 1 to 2: magnitude, band test, scale by 1/eps
    always_comb begin
        mag                = psi_reg[31] ? (32'd0 - psi_reg) : psi_reg;
        s2_next            = '0;
        s2_next.valid      = v1_reg;
        s2_next.neg        = psi_reg[31];
        s2_next.outside    = mag > {1'b0, half_width};
        prod_next          = 64'(mag) * 64'(inverse_half_width);
    end

    // stage 2 to 3: round, saturate, fold onto the rising half of the sine
    always_comb begin
        rnd        = prod_reg + HALF_F;
        mq         = rnd >> FRACTION_BITS;
        s3_next    = s2_reg;
        s3_next.m  = (mq > 64'(ONE_F)) ? ONE_F : mq[PHASE_W-1:0];
        y_next     = (s3_next.m > (ONE_F >> 1)) ? FRACTION_BITS'(ONE_F - s3_next.m)
                                                : FRACTION_BITS'(s3_next.m);
    end

    // stage 3 to 4: times pi
    assign pp_next = (FRACTION_BITS + 32)'(PI_Q30) * (FRACTION_BITS + 32)'(y_reg);

    // stage 4 to 5: square of the sine argument
    always_comb begin
        z          = pp_reg[FRACTION_BITS+30:FRACTION_BITS];
        s5_next    = s4_reg;
        s5_next.z  = z;
        z2p_next   = 62'(z) * 62'(z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
            s5_reg <= '0;
        end else if (ce) begin
            v1_reg <= in_valid;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s3_reg;
            s5_reg <= s5_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            psi_reg  <= in_distance;
            prod_reg <= prod_next;
            y_reg    <= y_next;
            pp_reg   <= pp_next;
            z2p_reg  <= z2p_next;
        end
    end

    assign side_out = s5_reg;
    assign z2_out   = z2p_reg[61:30];

endmodule

FILE: sv/shp_horner_cell.sv
// ----------------------------------------------------------------------------
// shp_horner_cell: one horner step of the sine series
// p_out = 1 - ((z2 * p_in) >> 30) / divisor, three register stages
// ----------------------------------------------------------------------------
module shp_horner_cell import shp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ce,
    input  logic [DIV_W-1:0] divisor,
    input  logic [31:0]      divisor_recip,
    input  side_t            side_in,
    input  logic [31:0]      z2_in,
    input  logic [30:0]      p_in,
    output side_t            side_out,
    output logic [31:0]      z2_out,
    output logic [30:0]      p_out
);

    side_t       side_a_reg, side_b_reg, side_c_reg;
    logic [31:0] z2_a_reg, z2_b_reg, z2_c_reg;
    logic [62:0] prod_a_reg, prod_a_next;
    logic [31:0] t_b_reg, t_b_next;
    logic [63:0] qe_b_reg, qe_b_next;
    logic [30:0] p_c_reg, p_c_next;

    logic [31:0] q_est;
    logic [38:0] qc;
    logic [31:0] rem;
    logic [31:0] q;

    assign prod_a_next = 63'(z2_in) * 63'(p_in);
    assign t_b_next    = prod_a_reg[61:30];
    assign qe_b_next   = 64'(t_b_next) * 64'(divisor_recip);

    // reciprocal estimate, then one correction step
    always_comb begin
        q_est    = qe_b_reg[63:32];
        qc       = 39'(q_est) * 39'(divisor);
        rem      = t_b_reg - qc[31:0];
        q        = (rem >= 32'(divisor)) ? (q_est + 32'd1) : q_est;
        p_c_next = 31'(32'(ONE_Q30) - q);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_a_reg <= '0;
            side_b_reg <= '0;
            side_c_reg <= '0;
        end else if (ce) begin
            side_a_reg <= side_in;
            side_b_reg <= side_a_reg;
            side_c_reg <= side_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            z2_a_reg   <= z2_in;
            prod_a_reg <= prod_a_next;
            z2_b_reg   <= z2_a_reg;
            t_b_reg    <= t_b_next;
            qe_b_reg   <= qe_b_next;
            z2_c_reg   <= z2_b_reg;
            p_c_reg    <= p_c_next;
        end
    end

    assign side_out = side_c_reg;
    assign z2_out   = z2_c_reg;
    assign p_out    = p_c_reg;

endmodule

FILE: sv/shp_back.sv
// ----------------------------------------------------------------------------
// shp_back: sine, heaviside sum and rounding to the q1.f phase fraction
// two register stages, result is combinational from the last one
// ----------------------------------------------------------------------------
module shp_back import shp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               ce,
    input  side_t              side_in,
    input  logic [30:0]        p_in,
    output logic               res_valid,
    output logic [PHASE_W-1:0] res_phase
);

    side_t       s1_reg, s2_reg;
    logic [61:0] sp_reg, sp_next;
    logic [58:0] gp_reg, gp_next;

    logic [30:0] s;
    logic [30:0] x;
    logic [30:0] g;
    logic [31:0] a_sum;
    logic [30:0] a;
    logic [31:0] res_w;

    assign sp_next = 62'(side_in.z) * 62'(p_in);

    always_comb begin
        s       = sp_reg[60:30];
        gp_next = 59'(s) * 59'(INV2PI_Q30);
    end

    always_comb begin
        x     = 31'(s2_reg.m) << Q30_SHIFT;
        g     = {1'b0, x[30:1]} + 31'(gp_reg[58:30]);
        a_sum = 32'(HALF_Q30) + 32'(g);
        if (s2_reg.neg) begin
            a = (a_sum > 32'(ONE_Q30)) ? ONE_Q30 : a_sum[30:0];
        end else begin
            a = (g >= HALF_Q30) ? 31'd0 : (HALF_Q30 - g);
        end
        res_w = (32'(a) + 32'(ROUND_Q30)) >> Q30_SHIFT;
        if (s2_reg.outside) begin
            res_phase = s2_reg.neg ? ONE_F : '0;
        end else begin
            res_phase = (res_w > 32'(ONE_F)) ? ONE_F : res_w[PHASE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
            s2_reg <= '0;
        end else if (ce) begin
            s1_reg <= side_in;
            s2_reg <= s1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sp_reg <= sp_next;
            gp_reg <= gp_next;
        end
    end

    assign res_valid = s2_reg.valid;

endmodule

FILE: sv/smoothed_heaviside_phase_unit.sv
// ----------------------------------------------------------------------------
// smoothed_heaviside_phase_unit: level-set smoothed heaviside phase fraction
// one distance beat in, alpha = 1 - H(psi) beat out, fully pipelined
// ----------------------------------------------------------------------------
// Takes one beat per clock while the skid register is empty and returns one
// beat per input beat, in order. A result passes through five front stages
// (band test, scaling by the reciprocal, fold, pi product, square), five
// horner cells of three stages each, two stages for the sine and heaviside
// sum, and the output register. The sustained rate is one beat per cycle;
// the whole chain moves together and holds only while the skid register
// behind the output is full. half_width and inverse_half_width must be
// written through the plain write port only while the unit is idle and kept
// reciprocal to each other; the unit itself enforces neither.
module smoothed_heaviside_phase_unit import shp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [0:0]             cfg_addr,
    input  logic [31:0]            cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // [31:0] distance_value
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [16:0] phase_fraction, rest zero
);

    // configuration registers
    logic [30:0] half_width_reg;
    logic [31:0] inverse_half_width_reg;

    // chain enable, the whole pipe steps together
    logic ce;

    // links between front, horner cells and back end
    side_t       chain_side [HORNER_CELLS+1];
    logic [31:0] chain_z2   [HORNER_CELLS+1];
    logic [30:0] chain_p    [HORNER_CELLS+1];

    logic               res_valid;
    logic [PHASE_W-1:0] res_phase;

    // output register and skid register
    logic               out_valid_reg;
    logic [PHASE_W-1:0] out_data_reg;
    logic               skid_valid_reg;
    logic [PHASE_W-1:0] skid_data_reg;
    logic               out_free;
    logic               push;

    // configuration writes, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg         <= 31'(ONE_F);
            inverse_half_width_reg <= 32'(ONE_F);
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_addr))
                REG_HALF_WIDTH:         half_width_reg         <= cfg_wdata[30:0];
                REG_INVERSE_HALF_WIDTH: inverse_half_width_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // the pipe moves whenever the skid register is free
    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    shp_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .ce                 (ce),
        .in_valid           (s_tvalid),
        .in_distance        (s_tdata),
        .half_width         (half_width_reg),
        .inverse_half_width (inverse_half_width_reg),
        .side_out           (chain_side[0]),
        .z2_out             (chain_z2[0])
    );

    // innermost horner term starts from one
    assign chain_p[0] = ONE_Q30;

    // row of horner cells, one divisor each
    for (genvar i = 0; i < HORNER_CELLS; i++) begin : g_cell
        shp_horner_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ce            (ce),
            .divisor       (HORNER_DIV[i]),
            .divisor_recip (HORNER_RECIP[i]),
            .side_in       (chain_side[i]),
            .z2_in         (chain_z2[i]),
            .p_in          (chain_p[i]),
            .side_out      (chain_side[i+1]),
            .z2_out        (chain_z2[i+1]),
            .p_out         (chain_p[i+1])
        );
    end

    shp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .side_in   (chain_side[HORNER_CELLS]),
        .p_in      (chain_p[HORNER_CELLS]),
        .res_valid (res_valid),
        .res_phase (res_phase)
    );

    // z2 leaving the last cell has no further use
    logic [31:0] z2_tail;
    assign z2_tail = chain_z2[HORNER_CELLS];

    // a result beat leaves the chain only when it steps
    assign push     = ce && res_valid;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            priority if (skid_valid_reg && out_free) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else if (push && out_free) begin
                out_valid_reg  <= 1'b1;
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end else if (out_free) begin
                out_valid_reg  <= 1'b0;
            end else begin
                out_valid_reg  <= out_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg && out_free) begin
            out_data_reg <= skid_data_reg;
        end else if (push && out_free) begin
            out_data_reg <= res_phase;
        end
        if (push && !out_free) begin
            skid_data_reg <= res_phase;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg) | OUT_TDATA_W'(z2_tail & 32'd0);

`ifndef SYNTH
    // a held skid beat always sits behind a held output beat
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid)
        else $error("skid register full while output register empty");

    // the skid register drains the cycle after the output is taken
    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> !skid_valid_reg)
        else $error("skid register did not drain");

    // the phase fraction never exceeds one
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata <= OUT_TDATA_W'(ONE_F)))
        else $error("phase fraction out of range");
`endif

endmodule

FILE: sim/smoothed_heaviside_phase_unit_tb.sv
// ----------------------------------------------------------------------------
// smoothed_heaviside_phase_unit_tb: self-checking bench for the phase unit
// streams signed distances through the unit under several half-width
// settings and checks every phase beat against a bit-exact predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module smoothed_heaviside_phase_unit_tb import shp_pkg::*; ();

    // unit latency; the final wait adds its own margin
    localparam int LATENCY      = 23;
    localparam int QUIET_LIMIT  = 4000;
    localparam int NUM_PHASES   = 9;
    localparam int PHASE_ITEMS  = 200;
    localparam int BLOCK_ITEMS  = 50;
    localparam int REPORT_LIMIT = 50;

    // predictor constants, unsigned q2.30 band maths
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned Q30_HALF    = 64'd1 << 29;
    localparam longint unsigned Q30_PI      = 64'd3373259426;
    localparam longint unsigned Q30_INV2PI  = 64'd170891319;
    localparam longint unsigned F_ONE       = 64'd1 << FRACTION_BITS;
    localparam int              TO_F_SHIFT  = 30 - FRACTION_BITS;
    // taylor divisors of the sine series, innermost first
    localparam int unsigned     SERIES_DIV [5] = '{110, 72, 42, 20, 6};

    // directed probe: distance, and a hand-worked phase where obvious
    typedef struct packed {
        logic [31:0]        distance;
        logic               pinned;
        logic [PHASE_W-1:0] phase;
    } probe_t;

    localparam int NUM_PROBES = 16;
    // probes assume the reset half width and reciprocal of one
    localparam probe_t PROBES [NUM_PROBES] = '{
        '{32'h0000_0000, 1'b1, 17'd32768},   // centre of the band, one half
        '{32'h0001_0000, 1'b1, 17'd0},       // upper band edge
        '{32'hFFFF_0000, 1'b1, 17'd65536},   // lower band edge
        '{32'h0001_0001, 1'b1, 17'd0},       // just above the band
        '{32'hFFFE_FFFF, 1'b1, 17'd65536},   // just below the band
        '{32'h7FFF_FFFF, 1'b1, 17'd0},       // most positive distance
        '{32'h8000_0000, 1'b1, 17'd65536},   // most negative distance
        '{32'h0000_0001, 1'b0, 17'd0},
        '{32'hFFFF_FFFF, 1'b0, 17'd0},
        '{32'h0000_8000, 1'b0, 17'd0},
        '{32'hFFFF_8000, 1'b0, 17'd0},
        '{32'h0000_4000, 1'b0, 17'd0},
        '{32'hFFFF_C000, 1'b0, 17'd0},
        '{32'h0000_FFFF, 1'b0, 17'd0},
        '{32'hFFFF_0001, 1'b0, 17'd0},
        '{32'h0000_2AAB, 1'b0, 17'd0}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [0:0]             cfg_addr  = REG_HALF_WIDTH;
    logic [31:0]            cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata   = '0;   // [31:0] distance_value
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [16:0] phase_fraction, rest zero

    // mirror of the unit's registers, as last written
    logic [30:0]        eps_now   = 31'd65536;
    logic [31:0]        recip_now = 32'd65536;

    // phases still owed by the unit, oldest first
    logic [PHASE_W-1:0] pending_phase [$];
    logic               pin_next  = 1'b0;
    logic [PHASE_W-1:0] pin_phase = '0;
    bit                 idle_on   = 1'b1;
    int                 stall_left = 0;

    int unsigned        beats_in      = 0;
    int unsigned        beats_checked = 0;
    int unsigned        band_beats    = 0;
    int unsigned        mismatches    = 0;
    int unsigned        quiet_cycles  = 0;

    smoothed_heaviside_phase_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // alpha = 1 - H(psi), worked out in the same fixed-point steps as the unit
    function automatic logic [PHASE_W-1:0] smoothed_phase(input logic [31:0] raw,
                                                          input logic [30:0] eps,
                                                          input logic [31:0] recip);
        longint unsigned mag, m, x, y, z, z2, p, s, g, a, r;
        logic            neg;
        neg = raw[31];
        mag = neg ? ((64'd1 << 32) - 64'(raw)) : 64'(raw);
        // outside the band the phase is flat
        if (mag > 64'(eps))
            return neg ? PHASE_W'(F_ONE) : '0;
        // |t| = |psi| / eps via the reciprocal, rounded half up, capped at one
        m = (mag * 64'(recip) + (F_ONE >> 1)) >> FRACTION_BITS;
        if (m > F_ONE)
            m = F_ONE;
        x = m << TO_F_SHIFT;
        // fold so that sin(pi x) only needs [0, pi/2]
        y = (x > Q30_HALF) ? (Q30_ONE - x) : x;
        z = (Q30_PI * y) >> 30;
        z2 = (z * z) >> 30;
        p = Q30_ONE;
        foreach (SERIES_DIV[k])
            p = Q30_ONE - ((z2 * p) >> 30) / SERIES_DIV[k];
        s = (z * p) >> 30;
        g = (x >> 1) + ((s * Q30_INV2PI) >> 30);
        if (neg) begin
            a = Q30_HALF + g;
            if (a > Q30_ONE)
                a = Q30_ONE;
        end else begin
            a = (g >= Q30_HALF) ? 64'd0 : (Q30_HALF - g);
        end
        r = (a + ((64'd1 << TO_F_SHIFT) >> 1)) >> TO_F_SHIFT;
        if (r > F_ONE)
            r = F_ONE;
        return r[PHASE_W-1:0];
    endfunction

    // mostly distances inside the band, some on its edges, the rest anywhere
    function automatic logic [31:0] pick_distance(input logic [30:0] eps);
        logic [31:0] mag;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
            mag = $urandom_range(0, 32'(eps));
        else if (kind == 6)
            mag = 32'(eps) + $urandom_range(0, 2) - 32'd1;
        else
            return $urandom;
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // one distance beat; entered and left on a falling edge
    task automatic send_distance(input logic [31:0] value, input logic pinned,
                                 input logic [PHASE_W-1:0] phase);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        pin_next  = pinned;
        pin_phase = phase;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // sender holds off until every owed phase beat has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_phase.size() != 0);
    endtask

    // both registers back to back, only while the unit is empty
    task automatic write_settings(input logic [30:0] eps, input logic [31:0] recip);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_HALF_WIDTH;
        // bit 31 is beyond the half-width register and must be dropped
        cfg_wdata <= {1'($urandom_range(0, 1)), eps};
        @(negedge aclk);
        cfg_addr  <= REG_INVERSE_HALF_WIDTH;
        cfg_wdata <= recip;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        eps_now   = eps;
        recip_now = recip;
    endtask

    // receiver: random stall bursts while idling is on
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(1, 11) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // scoreboard and watchdog, all on the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            // output side first, so a beat never matches its own input edge
            if (m_tvalid && m_tready) begin
                if (pending_phase.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: phase beat with nothing owed, got %0d",
                                 $time, m_tdata);
                end else begin
                    if (m_tdata !== OUT_TDATA_W'(pending_phase[0])) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: phase_fraction expected %0d, got %0d (tdata %h)",
                                     $time, pending_phase[0], m_tdata[PHASE_W-1:0],
                                     m_tdata);
                    end
                    void'(pending_phase.pop_front());
                    beats_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                pending_phase.push_back(pin_next ? pin_phase
                                                 : smoothed_phase(s_tdata, eps_now,
                                                                  recip_now));
                beats_in++;
                if ((s_tdata[31] ? -s_tdata : s_tdata) <= 32'(eps_now))
                    band_beats++;
            end
            // a run that stops moving is a failure
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic [30:0]     eps;
        logic [31:0]     recip;
        longint unsigned quotient;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed probes on the reset settings
        for (int i = 0; i < NUM_PROBES; i++)
            send_distance(PROBES[i].distance, PROBES[i].pinned, PROBES[i].phase);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin eps = 31'd32768;      recip = 32'd131072;     end
                1: begin eps = 31'd1;          recip = 32'hFFFF_FFFF;  end
                2: begin eps = 31'h7FFF_FFFF;  recip = 32'd2;          end
                // reciprocal far too large, |t| hits its cap
                3: begin eps = 31'h7FFF_FFFF;  recip = 32'hFFFF_FFFF;  end
                // zero half width, only a zero distance falls in the band
                4: begin eps = 31'd0;          recip = 32'd65536;      end
                // back to the reset values for the final run without idling
                8: begin eps = 31'd65536;      recip = 32'd65536;      end
                default: begin
                    eps = $urandom_range(0, 1) ? 31'($urandom_range(1, 1 << 20))
                                               : 31'($urandom_range(1, 32'h7FFF_FFFF));
                    quotient = (64'd1 << 32) / 64'(eps);
                    recip = (quotient > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(quotient);
                    if ($urandom_range(0, 2) == 0)
                        recip = $urandom_range(1, 32'hFFFF_FFFF);
                end
            endcase
            drain_results();
            write_settings(eps, recip);

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // idling in random blocks, none at all in the last setting
                if (i % BLOCK_ITEMS == 0)
                    idle_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                // one extra hold-off mid-stream until the pipe is empty
                if (ph == 5 && i == PHASE_ITEMS / 2)
                    drain_results();
                send_distance(pick_distance(eps), 1'b0, '0);
            end
        end

        drain_results();
        repeat (LATENCY + 8) @(posedge aclk);
        if (pending_phase.size() != 0)
            mismatches++;

        $display("%0d distance beats sent, %0d phase beats checked, %0d inside the band",
                 beats_in, beats_checked, band_beats);
        $display("%0d half-width settings including zero, minimum, maximum and mismatched",
                 NUM_PHASES + 1);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
